[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[sv/asmv_pkg.sv]
// ----------------------------------------------------------------------------
// asmv_pkg
// Widths, register codes, state and command types of the autoranging scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asmv_pkg;

  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned RANGE_BITS  = SAMPLE_BITS + 1;
  localparam int unsigned CC_BITS     = 7;
  localparam int unsigned CHAN_BITS   = 5;

  // product of offset and output span, rounded up to an even bit count
  localparam int unsigned PROD_BITS  = ((RANGE_BITS + CC_BITS + 1) / 2) * 2;
  localparam int unsigned REM_BITS   = RANGE_BITS + 1;
  localparam int unsigned ACC_BITS   = REM_BITS + PROD_BITS;
  localparam int unsigned DIV_STEPS  = PROD_BITS / 2;
  localparam int unsigned STEP_BITS  = $clog2(DIV_STEPS);

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 7;

  localparam logic [RANGE_BITS-1:0] MIN_RESET = {1'b1, {SAMPLE_BITS{1'b0}}};
  localparam logic [CC_BITS-1:0]    OUT_MIN_RESET = '0;
  localparam logic [CC_BITS-1:0]    OUT_MAX_RESET = '1;
  localparam logic [CHAN_BITS-1:0]  CHAN_RESET    = CHAN_BITS'(1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INVERTED   = 3'd0,
    REG_OUT_MIN    = 3'd1,
    REG_OUT_MAX    = 3'd2,
    REG_CHANNEL    = 3'd3,
    REG_CONTROLLER = 3'd4
  } asmv_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRACK,
    ST_SCALE,
    ST_DIVIDE,
    ST_RESULT
  } asmv_state_e;

  typedef struct packed {
    logic capture;
    logic track;
    logic scale;
    logic step;
    logic finish;
  } asmv_cmd_t;

  typedef struct packed {
    logic div_last;
    logic changed;
  } asmv_sts_t;

endpackage

[sv/asmv_ctrl.sv]
// ----------------------------------------------------------------------------
// asmv_ctrl
// Sequencer for one sample: track range, scale, divide, deliver result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asmv_ctrl import asmv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  asmv_sts_t sts_i,
  output asmv_cmd_t cmd_o
);

  asmv_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    // drop the held result once it is taken
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_TRACK;
        end
      end
      ST_TRACK: begin
        cmd_o.track = 1'b1;
        state_d     = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // hold while the previous result is still waiting
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = sts_i.changed;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/asmv_dp.sv]
// ----------------------------------------------------------------------------
// asmv_dp
// Range tracking, scaling multiply, radix-4 restoring divider, result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asmv_dp import asmv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  asmv_cmd_t                cmd_i,
  output asmv_sts_t                sts_o,
  output logic [CC_BITS-1:0]       cc_value_o,
  output logic [CHAN_BITS-1:0]     channel_out_o,
  output logic [CC_BITS-1:0]       control_out_o
);

  // one restoring division step: shift in the next dividend bit, subtract if it fits
  function automatic logic [ACC_BITS-1:0] div_step(input logic [ACC_BITS-1:0] acc,
                                                   input logic [RANGE_BITS-1:0] span);
    logic [REM_BITS-1:0]  rem;
    logic [PROD_BITS-1:0] quo;
    logic [REM_BITS-1:0]  trial;
    logic                 fits;
    rem   = acc[ACC_BITS-1:PROD_BITS];
    quo   = acc[PROD_BITS-1:0];
    trial = {rem[REM_BITS-2:0], quo[PROD_BITS-1]};
    fits  = trial >= {1'b0, span};
    if (fits) begin
      trial = trial - {1'b0, span};
    end
    return {trial, quo[PROD_BITS-2:0], fits};
  endfunction

  logic                   inverted_q;
  logic [CC_BITS-1:0]     out_min_q, out_max_q, controller_q;
  logic [CHAN_BITS-1:0]   channel_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [RANGE_BITS-1:0]  min_q, max_q, min_d, max_d;
  logic [CC_BITS-1:0]     last_q;
  logic [RANGE_BITS-1:0]  span_q;
  logic                   neg_q;
  logic [ACC_BITS-1:0]    acc_q;
  logic [STEP_BITS-1:0]   cnt_q;
  logic [CC_BITS-1:0]     cc_value_q, control_q;
  logic [CHAN_BITS-1:0]   chan_out_q;

  logic [RANGE_BITS-1:0]  s_ext;
  logic [RANGE_BITS-1:0]  num;
  logic [CC_BITS:0]       diff;
  logic [CC_BITS-1:0]     mag;
  logic [PROD_BITS-1:0]   prod;
  logic [ACC_BITS-1:0]    acc_step;
  logic                   round_up;
  logic [CC_BITS:0]       qmag, value_w;
  logic [CC_BITS-1:0]     value;

  assign s_ext = {1'b0, sample_q};

  // widen the range to cover the sample, keep it at least one count wide
  always_comb begin
    min_d = (s_ext < min_q) ? s_ext : min_q;
    max_d = (s_ext > max_q) ? s_ext : max_q;
    if (min_d >= max_d) begin
      if (max_d != '0) begin
        min_d = max_d - RANGE_BITS'(1);
      end else begin
        max_d = min_d + RANGE_BITS'(1);
      end
    end
  end

  always_comb begin
    num  = inverted_q ? (max_q - s_ext) : (s_ext - min_q);
    diff = {1'b0, out_max_q} - {1'b0, out_min_q};
    mag  = diff[CC_BITS] ? CC_BITS'(-diff) : diff[CC_BITS-1:0];
    prod = PROD_BITS'(num) * PROD_BITS'(mag);
  end

  assign acc_step = div_step(div_step(acc_q, span_q), span_q);

  // floor for a negative scale: round the quotient magnitude up on a remainder
  always_comb begin
    round_up = neg_q && (acc_q[ACC_BITS-1:PROD_BITS] != '0);
    qmag     = {1'b0, acc_q[CC_BITS-1:0]} + (CC_BITS+1)'(round_up);
    value_w  = neg_q ? ({1'b0, out_min_q} - qmag) : ({1'b0, out_min_q} + qmag);
    value    = value_w[CC_BITS-1:0];
  end

  assign sts_o.changed  = value != last_q;
  assign sts_o.div_last = cnt_q == STEP_BITS'(DIV_STEPS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inverted_q   <= 1'b0;
      out_min_q    <= OUT_MIN_RESET;
      out_max_q    <= OUT_MAX_RESET;
      channel_q    <= CHAN_RESET;
      controller_q <= '0;
      min_q        <= MIN_RESET;
      max_q        <= '0;
      last_q       <= OUT_MIN_RESET;
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_INVERTED:   inverted_q   <= cfg_data_i[0];
          REG_OUT_MIN:    out_min_q    <= cfg_data_i;
          REG_OUT_MAX:    out_max_q    <= cfg_data_i;
          REG_CHANNEL:    channel_q    <= cfg_data_i[CHAN_BITS-1:0];
          REG_CONTROLLER: controller_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.track) begin
        min_q <= min_d;
        max_q <= max_d;
      end
      if (cmd_i.scale) begin
        cnt_q <= '0;
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q + STEP_BITS'(1);
      end
      if (cmd_i.finish && sts_o.changed) begin
        last_q <= value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= sample_i;
    end
    if (cmd_i.scale) begin
      span_q <= max_q - min_q;
      neg_q  <= diff[CC_BITS];
      acc_q  <= {{REM_BITS{1'b0}}, prod};
    end else if (cmd_i.step) begin
      acc_q <= acc_step;
    end
    if (cmd_i.finish && sts_o.changed) begin
      cc_value_q <= value;
      chan_out_q <= channel_q;
      control_q  <= controller_q;
    end
  end

  assign cc_value_o    = cc_value_q;
  assign channel_out_o = chan_out_q;
  assign control_out_o = control_q;

endmodule

[sv/autoranging_sensor_to_midi_value.sv]
// Sequence: a sample accepted in the idle state passes range tracking, scaling,
// the 9 radix-4 steps of the shared divider and the result state, which loads
// its result, if any, and holds while an older result waits for transfer.
// A new sample is taken only after the result state has been left.
// Reset: asynchronous, clears the range to min 1024 / max 0, the last value to
// 0 and the registers to their defaults; no clearing pass, ready at once.
// ----------------------------------------------------------------------------
// autoranging_sensor_to_midi_value
// Scales raw converter samples onto a control value over the self-learnt range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module autoranging_sensor_to_midi_value import asmv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration writes, always taken
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  // sample channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  // control-change channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CC_BITS-1:0]       cc_value_o,
  output logic [CHAN_BITS-1:0]     channel_out_o,
  output logic [CC_BITS-1:0]       control_out_o
);

  asmv_cmd_t cmd;
  asmv_sts_t sts;

  // Registers are plain flops: a transfer lands the same cycle.
  assign cfg_ready_o = 1'b1;

  // Controller: one sample at a time, capture -> track -> scale -> divide ->
  // result. The result register lets a new sample in while it waits.
  asmv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: range registers, one 11x7 multiply, two divide steps a cycle,
  // floor correction and change detection against the last value.
  asmv_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (sample_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cc_value_o    (cc_value_o),
    .channel_out_o (channel_out_o),
    .control_out_o (control_out_o)
  );

  // A sample transfer makes the block busy for the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  // The sequencer issues at most one command a cycle.
  `ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "several commands at once")
  // A pending result is never overwritten.
  `ASSERT_IMPLIES(a_no_overwrite, cmd.finish, !out_valid_o || out_ready_i, "result overwritten")
  // Range tracking always follows a captured sample.
  `ASSERT_NEXT(a_track_after_capture, cmd.capture, cmd.track, "capture without track")

endmodule
